### rtl/core/perfect_hash_djb_index_assert.svh
// Assertion macros for the perfect hash index block.
// Included by the top level; needs no package.
`ifndef PERFECT_HASH_DJB_INDEX_ASSERT_SVH
`define PERFECT_HASH_DJB_INDEX_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define PHD_ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define PHD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/phd_pkg.sv
// Shared types, constants and hash step for the perfect hash index block.
// No dependencies; imported by every module of the block.
`default_nettype none

package phd_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned ADDR_IN_W  = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned PHD_TABLE_DEPTH = 4096;

  // Quotient by reciprocal: q = (x * ceil(2^RED_SHIFT / depth)) >> RED_SHIFT,
  // exact for any 12-bit x and any depth up to 2^ADDR_IN_W.
  localparam int unsigned RED_SHIFT  = 24;
  localparam int unsigned RED_MULT_W = RED_SHIFT + 1;

  localparam logic [CFG_IDX_W-1:0] REG_SEED_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_MASK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_MASK  = 3'd3;

  typedef struct packed {
    logic [WORD_W-1:0]    seed_first;
    logic [WORD_W-1:0]    seed_second;
    logic [ADDR_IN_W-1:0] vertex_mask;
  } phd_cfg_t;

  // Transaction leaving the hash pipe toward the table stage.
  typedef struct packed {
    logic                 is_write;
    logic [ADDR_IN_W-1:0] xa;
    logic [ADDR_IN_W-1:0] xb;
    logic [ADDR_IN_W-1:0] qa;
    logic [ADDR_IN_W-1:0] qb;
    logic [WORD_W-1:0]    wval;
  } phd_slot_t;

  // One DJB step: h * 33 + b, wrapping at 32 bits.
  function automatic logic [WORD_W-1:0] djb_step(input logic [WORD_W-1:0] h,
                                                 input logic [7:0] b);
    return (h << 5) + h + {24'd0, b};
  endfunction

endpackage

`default_nettype wire

### rtl/core/perfect_hash_djb_index.sv
// Throughput: one transaction per cycle unless out_ready_i stalls the output;
// the table memory has two read ports and one write port, never used in the
// same cycle, and writes and reads issue in order from one stage. Reset clears
// the pipeline valid bits and loads register defaults; the vertex table has no
// clearing pass and holds undefined words until written.
// Depends on phd_pkg, phd_hash_pipe, phd_vertex_mem and the assertion header.
`default_nettype none

`include "perfect_hash_djb_index_assert.svh"

module perfect_hash_djb_index import phd_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = PHD_TABLE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 kind_i,
  input  logic [KEY_W-1:0]     key_i,
  input  logic [ADDR_IN_W-1:0] entry_address_i,
  input  logic [WORD_W-1:0]    entry_value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [WORD_W-1:0]    index_o
);

  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);

  logic [WORD_W-1:0]    seed_first_q, seed_first_d;
  logic [WORD_W-1:0]    seed_second_q, seed_second_d;
  logic [ADDR_IN_W-1:0] vertex_mask_q, vertex_mask_d;
  logic [WORD_W-1:0]    index_mask_q, index_mask_d;
  phd_cfg_t             cfg;

  logic      c_valid, c_ready;
  phd_slot_t c_slot;

  logic [WORD_W-1:0]    qd_a, qd_b;
  logic [ADDR_IN_W-1:0] rem_a, rem_b;
  logic [ADDR_W-1:0]    addr_a, addr_b;
  logic                 mem_we, mem_re;
  logic [WORD_W-1:0]    rdata_a, rdata_b;

  logic              m_valid_q, m_valid_d;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] index_q, index_d;
  logic              en_o, en_m;

  // Configuration registers.
  always_comb begin
    seed_first_d  = seed_first_q;
    seed_second_d = seed_second_q;
    vertex_mask_d = vertex_mask_q;
    index_mask_d  = index_mask_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SEED_FIRST:  seed_first_d  = cfg_data_i;
        REG_SEED_SECOND: seed_second_d = cfg_data_i;
        REG_VERTEX_MASK: vertex_mask_d = cfg_data_i[ADDR_IN_W-1:0];
        REG_INDEX_MASK:  index_mask_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_first_q  <= '0;
      seed_second_q <= '0;
      vertex_mask_q <= '1;
      index_mask_q  <= '1;
    end else begin
      seed_first_q  <= seed_first_d;
      seed_second_q <= seed_second_d;
      vertex_mask_q <= vertex_mask_d;
      index_mask_q  <= index_mask_d;
    end
  end

  assign cfg.seed_first  = seed_first_q;
  assign cfg.seed_second = seed_second_q;
  assign cfg.vertex_mask = vertex_mask_q;

  phd_hash_pipe #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_hash_pipe (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .key_i           (key_i),
    .entry_address_i (entry_address_i),
    .entry_value_i   (entry_value_i),
    .out_valid_o     (c_valid),
    .out_ready_i     (c_ready),
    .out_slot_o      (c_slot)
  );

  // Reduce each address modulo the table depth: subtract quotient times depth.
  always_comb begin
    qd_a   = 32'(c_slot.qa) * 32'(TABLE_DEPTH);
    qd_b   = 32'(c_slot.qb) * 32'(TABLE_DEPTH);
    rem_a  = c_slot.xa - qd_a[ADDR_IN_W-1:0];
    rem_b  = c_slot.xb - qd_b[ADDR_IN_W-1:0];
    addr_a = ADDR_W'(rem_a);
    addr_b = ADDR_W'(rem_b);
  end

  assign en_o    = !out_valid_q || out_ready_i;
  assign en_m    = !m_valid_q || en_o;
  assign c_ready = en_m;

  // Writes and lookups leave the hash pipe in order, so the table sees them
  // in order: no forwarding needed.
  assign mem_we = c_valid && en_m && c_slot.is_write;
  assign mem_re = c_valid && en_m && !c_slot.is_write;

  phd_vertex_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_vertex_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (addr_a),
    .wdata_i   (c_slot.wval),
    .re_i      (mem_re),
    .raddr_a_i (addr_a),
    .raddr_b_i (addr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Drop write transactions here; only lookups carry a result.
  always_comb begin
    m_valid_d   = en_m ? (c_valid && !c_slot.is_write) : m_valid_q;
    out_valid_d = en_o ? m_valid_q : out_valid_q;
    index_d     = (rdata_a + rdata_b) & index_mask_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      m_valid_q   <= m_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o && m_valid_q) begin
      index_q <= index_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign index_o     = index_q;

  `PHD_ASSERT_HOLDS(a_mem_port_excl, clk_i, rst_ni, !(mem_we && mem_re),
    "table read and write issued in the same cycle")
  `PHD_ASSERT_HOLDS(a_addr_range, clk_i, rst_ni,
    !c_valid || (32'(addr_a) < TABLE_DEPTH && 32'(addr_b) < TABLE_DEPTH),
    "reduced table address beyond depth")
  `PHD_ASSERT_NEXT(a_lookup_reaches_mem, clk_i, rst_ni,
    c_valid && c_ready && !c_slot.is_write, m_valid_q,
    "lookup lost between hash pipe and table stage")
  `PHD_ASSERT_NEXT(a_write_no_result, clk_i, rst_ni,
    c_valid && c_ready && c_slot.is_write, !m_valid_q,
    "table write produced a result")

endmodule

`default_nettype wire

### rtl/core/phd_hash_pipe.sv
// Three-stage hash pipe: DJB on key bytes 0-1; DJB on bytes 2-3 and vertex mask; address quotient.
// Depends on phd_pkg.
`default_nettype none

module phd_hash_pipe import phd_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = PHD_TABLE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  phd_cfg_t             cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 kind_i,
  input  logic [KEY_W-1:0]     key_i,
  input  logic [ADDR_IN_W-1:0] entry_address_i,
  input  logic [WORD_W-1:0]    entry_value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output phd_slot_t            out_slot_o
);

  localparam logic [RED_MULT_W-1:0] RED_MULT = RED_MULT_W'(
    ((64'd1 << RED_SHIFT) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH));
  localparam int unsigned PROD_W = ADDR_IN_W + RED_MULT_W;

  typedef struct packed {
    logic                 kind;
    logic [WORD_W-1:0]    ha;
    logic [WORD_W-1:0]    hb;
    logic [15:0]          key_hi;
    logic [ADDR_IN_W-1:0] waddr;
    logic [WORD_W-1:0]    wval;
  } stage_a_t;

  typedef struct packed {
    logic                 kind;
    logic [ADDR_IN_W-1:0] xa;
    logic [ADDR_IN_W-1:0] xb;
    logic [WORD_W-1:0]    wval;
  } stage_b_t;

  logic a_valid_q, a_valid_d;
  logic b_valid_q, b_valid_d;
  logic c_valid_q, c_valid_d;
  logic en_a, en_b, en_c;

  stage_a_t  a_q, a_d;
  stage_b_t  b_q, b_d;
  phd_slot_t c_q, c_d;

  logic [WORD_W-1:0] ha_fin, hb_fin;
  logic [PROD_W-1:0] prod_a, prod_b;

  // Each stage moves when empty or when the one below moves.
  assign en_c = !c_valid_q || out_ready_i;
  assign en_b = !b_valid_q || en_c;
  assign en_a = !a_valid_q || en_b;
  assign in_ready_o = en_a;

  always_comb begin
    a_valid_d = en_a ? in_valid_i : a_valid_q;
    b_valid_d = en_b ? a_valid_q : b_valid_q;
    c_valid_d = en_c ? b_valid_q : c_valid_q;
  end

  // Stage A: first two key bytes.
  always_comb begin
    a_d.kind   = kind_i;
    a_d.ha     = djb_step(djb_step(cfg_i.seed_first, key_i[7:0]), key_i[15:8]);
    a_d.hb     = djb_step(djb_step(cfg_i.seed_second, key_i[7:0]), key_i[15:8]);
    a_d.key_hi = key_i[31:16];
    a_d.waddr  = entry_address_i;
    a_d.wval   = entry_value_i;
  end

  // Stage B: last two key bytes, then mask to a table address; writes take the entry address unmasked.
  always_comb begin
    ha_fin = djb_step(djb_step(a_q.ha, a_q.key_hi[7:0]), a_q.key_hi[15:8]);
    hb_fin = djb_step(djb_step(a_q.hb, a_q.key_hi[7:0]), a_q.key_hi[15:8]);
    b_d.kind = a_q.kind;
    b_d.wval = a_q.wval;
    if (a_q.kind) begin
      b_d.xa = a_q.waddr;
      b_d.xb = a_q.waddr;
    end else begin
      b_d.xa = ha_fin[ADDR_IN_W-1:0] & cfg_i.vertex_mask;
      b_d.xb = hb_fin[ADDR_IN_W-1:0] & cfg_i.vertex_mask;
    end
  end

  // Stage C: quotient of each address by the table depth.
  always_comb begin
    prod_a      = PROD_W'(b_q.xa) * PROD_W'(RED_MULT);
    prod_b      = PROD_W'(b_q.xb) * PROD_W'(RED_MULT);
    c_d.is_write = b_q.kind;
    c_d.xa      = b_q.xa;
    c_d.xb      = b_q.xb;
    c_d.qa      = prod_a[RED_SHIFT +: ADDR_IN_W];
    c_d.qb      = prod_b[RED_SHIFT +: ADDR_IN_W];
    c_d.wval    = b_q.wval;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
      c_valid_q <= c_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      a_q <= a_d;
    end
    if (en_b) begin
      b_q <= b_d;
    end
    if (en_c) begin
      c_q <= c_d;
    end
  end

  assign out_valid_o = c_valid_q;
  assign out_slot_o  = c_q;

endmodule

`default_nettype wire

### rtl/core/phd_vertex_mem.sv
// Vertex table: one write port, two read ports, registered read data.
// Depends on phd_pkg.
`default_nettype none

module phd_vertex_mem import phd_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = PHD_TABLE_DEPTH,
  parameter int unsigned ADDR_W      = $clog2(TABLE_DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [WORD_W-1:0] rdata_a_o,
  output logic [WORD_W-1:0] rdata_b_o
);

  logic [WORD_W-1:0] mem_q [TABLE_DEPTH];
  logic [WORD_W-1:0] rdata_a_q, rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data while the consuming stage stalls.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire
